### rtl/core/pcldt_pkg.sv
// Shared constants and types for the pc/line delta table encoder.
// Used by pcldt_ctrl, pcldt_dp and pc_line_delta_table_encoder_core.
package pcldt_pkg;

    localparam int MAX_ADVANCE_BYTES = 59;
    localparam int PC_BITS           = 32;
    localparam int LINE_BITS         = 31;
    localparam int DELTA_BITS        = 32;
    localparam int BYTE_BITS         = 8;

    localparam int ADV_STEP_MAX = 127;
    localparam int ADV_LIMIT    = MAX_ADVANCE_BYTES * ADV_STEP_MAX;
    localparam int HALF_W       = $clog2(ADV_LIMIT + 1);

    localparam logic [BYTE_BITS-1:0] BYTE_PAD      = 8'd129;
    localparam logic [BYTE_BITS-1:0] BYTE_ZERO     = 8'd0;
    localparam logic [BYTE_BITS-1:0] BYTE_NEG_BASE = 8'd64;

    localparam logic REQ_RECORD = 1'b0;
    localparam logic REQ_END    = 1'b1;

    localparam logic [2:0] IDX_ESC = 3'd0;
    localparam logic [2:0] IDX_B3  = 3'd1;
    localparam logic [2:0] IDX_B2  = 3'd2;
    localparam logic [2:0] IDX_B1  = 3'd3;
    localparam logic [2:0] IDX_B0  = 3'd4;

    typedef struct packed {
        logic take;
        logic emit_one;
        logic emit_adv;
        logic emit_line;
    } t_cmd;

    typedef struct packed {
        logic pad;
        logic err;
        logic rec_ok;
        logic has_adv;
        logic adv_done;
        logic line_done;
        logic out_free;
    } t_status;

endpackage

### rtl/core/pcldt_ctrl.sv
// Sequencer for the pc/line delta table encoder.
// Depends on pcldt_pkg for the command and status structs.
module pcldt_ctrl import pcldt_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_ONE  = 2'd1;
    localparam logic [1:0] ST_ADV  = 2'd2;
    localparam logic [1:0] ST_LINE = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    assign o_stall = (r_state != ST_IDLE);

    always_comb begin
        n_state          = r_state;
        o_cmd            = '0;
        o_cmd.take       = i_valid && (r_state == ST_IDLE);
        unique case (r_state)
            ST_IDLE: begin
                if (o_cmd.take) begin
                    if (i_status.pad || i_status.err) begin
                        n_state = ST_ONE;
                    end else if (i_status.rec_ok) begin
                        n_state = i_status.has_adv ? ST_ADV : ST_LINE;
                    end
                end
            end
            ST_ONE: begin
                if (i_status.out_free) begin
                    o_cmd.emit_one = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            ST_ADV: begin
                if (i_status.out_free) begin
                    o_cmd.emit_adv = 1'b1;
                    if (i_status.adv_done) begin
                        n_state = ST_LINE;
                    end
                end
            end
            ST_LINE: begin
                if (i_status.out_free) begin
                    o_cmd.emit_line = 1'b1;
                    if (i_status.line_done) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### rtl/core/pcldt_dp.sv
// Datapath for the pc/line delta table encoder: state, classification,
// advance counter, line delta bytes and the output register. Uses pcldt_pkg.
module pcldt_dp import pcldt_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_req_type,
    input  logic [31:0]           i_pc,
    input  logic [LINE_BITS-1:0]  i_line,
    input  logic                  i_skip,
    input  t_cmd                  i_cmd,
    output t_status               o_status,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [BYTE_BITS-1:0]  o_table_byte,
    output logic                  o_last,
    output logic                  o_error
);

    localparam logic [PC_BITS-1:0]  PC_STEP      = PC_BITS'(2);
    localparam logic [PC_BITS-2:0]  ADV_LIMIT_PC = (PC_BITS-1)'(ADV_LIMIT);
    localparam logic [HALF_W-1:0]   STEP_MAX_H   = HALF_W'(ADV_STEP_MAX);
    localparam logic signed [DELTA_BITS-1:0] DELTA_HI = DELTA_BITS'(64);
    localparam logic signed [DELTA_BITS-1:0] DELTA_LO = -DELTA_BITS'(64);

    logic [PC_BITS-1:0]    r_prev_pc;
    logic [LINE_BITS-1:0]  r_prev_line;
    logic                  r_count_odd;

    logic [HALF_W-1:0]     r_halves;
    logic [DELTA_BITS-1:0] r_delta;
    logic                  r_long;
    logic [2:0]            r_idx;
    logic [BYTE_BITS-1:0]  r_one_byte;
    logic                  r_one_err;

    logic                  r_out_valid;
    logic [BYTE_BITS-1:0]  r_out_byte;
    logic                  r_out_last;
    logic                  r_out_err;

    logic [PC_BITS-1:0]           pc_m;
    logic [PC_BITS-1:0]           pc_diff;
    logic [PC_BITS-2:0]           halves_in;
    logic signed [DELTA_BITS-1:0] delta_in;
    logic                         is_rec;
    logic                         backward;
    logic                         too_far;
    logic [6:0]                   adv_step;
    logic [BYTE_BITS-1:0]         line_byte;
    logic                         emit;
    logic [BYTE_BITS-1:0]         emit_byte;
    logic                         emit_last;
    logic                         emit_err;

    assign pc_m      = i_pc[PC_BITS-1:0];
    assign pc_diff   = pc_m - r_prev_pc;
    assign halves_in = pc_diff[PC_BITS-1:1];
    assign delta_in  = $signed({1'b0, i_line}) - $signed({1'b0, r_prev_line});
    assign is_rec    = (i_req_type == REQ_RECORD) && !i_skip && (i_line != r_prev_line);
    assign backward  = pc_m < r_prev_pc;
    assign too_far   = halves_in > ADV_LIMIT_PC;

    assign adv_step = (r_halves < STEP_MAX_H) ? r_halves[6:0] : 7'(ADV_STEP_MAX);

    always_comb begin
        if (r_long) begin
            case (r_idx)
                IDX_ESC: line_byte = BYTE_ZERO;
                IDX_B3:  line_byte = r_delta[31:24];
                IDX_B2:  line_byte = r_delta[23:16];
                IDX_B1:  line_byte = r_delta[15:8];
                default: line_byte = r_delta[7:0];
            endcase
        end else if ($signed(r_delta) > 0) begin
            line_byte = r_delta[7:0];
        end else begin
            line_byte = BYTE_NEG_BASE - r_delta[7:0];
        end
    end

    always_comb begin
        o_status.pad       = (i_req_type == REQ_END) && r_count_odd;
        o_status.err       = is_rec && (backward || too_far);
        o_status.rec_ok    = is_rec && !backward && !too_far;
        o_status.has_adv   = (halves_in != '0);
        o_status.adv_done  = (r_halves <= STEP_MAX_H);
        o_status.line_done = !r_long || (r_idx == IDX_B0);
        o_status.out_free  = !r_out_valid || !i_stall;
    end

    assign emit = i_cmd.emit_one || i_cmd.emit_adv || i_cmd.emit_line;

    always_comb begin
        emit_byte = line_byte;
        emit_last = o_status.line_done;
        emit_err  = 1'b0;
        if (i_cmd.emit_one) begin
            emit_byte = r_one_byte;
            emit_last = 1'b1;
            emit_err  = r_one_err;
        end else if (i_cmd.emit_adv) begin
            emit_byte = {1'b1, adv_step};
            emit_last = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_pc   <= '0;
            r_prev_line <= '0;
            r_count_odd <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.take && o_status.rec_ok) begin
                r_prev_pc   <= pc_m + PC_STEP;
                r_prev_line <= i_line;
            end
            if (emit && !emit_err) begin
                r_count_odd <= !r_count_odd;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_one_byte <= o_status.err ? BYTE_ZERO : BYTE_PAD;
            r_one_err  <= o_status.err;
            if (o_status.rec_ok) begin
                r_halves <= halves_in[HALF_W-1:0];
                r_delta  <= delta_in;
                r_long   <= (delta_in > DELTA_HI) || (delta_in < DELTA_LO);
                r_idx    <= IDX_ESC;
            end
        end
        if (i_cmd.emit_adv) begin
            r_halves <= r_halves - HALF_W'(adv_step);
        end
        if (i_cmd.emit_line) begin
            r_idx <= r_idx + 3'd1;
        end
        if (emit) begin
            r_out_byte <= emit_byte;
            r_out_last <= emit_last;
            r_out_err  <= emit_err;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_table_byte = r_out_byte;
    assign o_last       = r_out_last;
    assign o_error      = r_out_err;

endmodule

### rtl/core/pc_line_delta_table_encoder_core.sv
// pc/line delta table encoder: top level joining pcldt_ctrl and pcldt_dp.
// The first table byte of a transaction is registered in the output register from
// an emit state. N = bytes emitted (0..64), one byte per cycle while i_stall is low;
// the advance counter sets N for long gaps. o_stall holds new input until all are out.
// Reset (i_rst_n low, synchronous) clears last pc, last line, parity and output valid.
module pc_line_delta_table_encoder_core import pcldt_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic                 i_req_type,
    input  logic [31:0]          i_pc,
    input  logic [LINE_BITS-1:0] i_line,
    input  logic                 i_skip,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [BYTE_BITS-1:0] o_table_byte,
    output logic                 o_last,
    output logic                 o_error
);

    t_cmd    cmd;
    t_status status;

    pcldt_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_status (status),
        .o_cmd    (cmd)
    );

    pcldt_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_type   (i_req_type),
        .i_pc         (i_pc),
        .i_line       (i_line),
        .i_skip       (i_skip),
        .i_cmd        (cmd),
        .o_status     (status),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_table_byte (o_table_byte),
        .o_last       (o_last),
        .o_error      (o_error)
    );

endmodule

### dv/pcldt_table_checker.sv
// Checker for pc_line_delta_table_encoder_core: predicts the table bytes of every
// accepted transaction and compares them, in order, with the output channel.
// Depends on pcldt_pkg for widths, request codes and byte codes.
module pcldt_table_checker import pcldt_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  logic                 i_req_type,
    input  logic [31:0]          i_pc,
    input  logic [LINE_BITS-1:0] i_line,
    input  logic                 i_skip,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  logic [BYTE_BITS-1:0] i_table_byte,
    input  logic                 i_last,
    input  logic                 i_error,
    output int                   o_fail_count,
    output int                   o_pending,
    output int                   o_bytes_checked,
    output int                   o_rejects
);

    localparam logic [BYTE_BITS-1:0] BYTE_ADV_BASE = 8'd128;
    localparam logic [31:0]          PC_MASK       = 32'((64'd1 << PC_BITS) - 1);
    localparam longint               SHORT_DELTA   = longint'(BYTE_NEG_BASE);

    typedef struct packed {
        logic [BYTE_BITS-1:0] value;
        logic                 last;
        logic                 err;
    } t_table_byte;

    t_table_byte expected_bytes[$];
    logic [31:0] pc_next;
    logic [31:0] line_prev;
    logic        parity;

    function automatic void expect_byte(input logic [BYTE_BITS-1:0] value,
                                        input logic last, input logic err);
        expected_bytes.push_back({value, last, err});
    endfunction

    task automatic encode_transaction(input logic req, input logic [31:0] pc_in,
                                      input logic [LINE_BITS-1:0] line, input logic skip);
        logic [31:0] pc;
        logic [31:0] halves;
        logic [31:0] chunk;
        logic [31:0] d;
        longint      delta;
        int          n;
        pc = pc_in & PC_MASK;
        if (req == REQ_END) begin
            if (parity) begin
                expect_byte(BYTE_PAD, 1'b1, 1'b0);
                parity = 1'b0;
            end
            return;
        end
        if (skip || {1'b0, line} == line_prev)
            return;
        halves = (pc - pc_next) >> 1;
        if (pc < pc_next ||
            (longint'(halves) + ADV_STEP_MAX - 1) / ADV_STEP_MAX > MAX_ADVANCE_BYTES) begin
            expect_byte(BYTE_ZERO, 1'b1, 1'b1);
            return;
        end
        n = 0;
        while (halves != 0) begin
            chunk = (halves < ADV_STEP_MAX) ? halves : ADV_STEP_MAX;
            expect_byte(BYTE_ADV_BASE + chunk[7:0], 1'b0, 1'b0);
            halves -= chunk;
            n++;
        end
        delta = longint'({1'b0, line}) - longint'(line_prev);
        if (delta > SHORT_DELTA || delta < -SHORT_DELTA) begin
            d = delta[31:0];
            expect_byte(BYTE_ZERO, 1'b0, 1'b0);
            expect_byte(d[31:24], 1'b0, 1'b0);
            expect_byte(d[23:16], 1'b0, 1'b0);
            expect_byte(d[15:8], 1'b0, 1'b0);
            expect_byte(d[7:0], 1'b1, 1'b0);
            n += 5;
        end else if (delta > 0) begin
            expect_byte(8'(delta), 1'b1, 1'b0);
            n++;
        end else begin
            expect_byte(8'(SHORT_DELTA - delta), 1'b1, 1'b0);
            n++;
        end
        parity ^= n[0];
        line_prev = {1'b0, line};
        pc_next = (pc + 32'd2) & PC_MASK;
    endtask

    always @(posedge i_clk) begin : track
        t_table_byte want;
        if (!i_rst_n) begin
            pc_next = '0;
            line_prev = '0;
            parity = 1'b0;
            expected_bytes.delete();
        end else begin
            if (i_in_valid && !i_in_stall)
                encode_transaction(i_req_type, i_pc, i_line, i_skip);
            if (i_out_valid && !i_out_stall) begin
                if (expected_bytes.size() == 0) begin
                    $error("unexpected table byte %0d (last %0b, error %0b)",
                           i_table_byte, i_last, i_error);
                    o_fail_count++;
                end else begin
                    want = expected_bytes.pop_front();
                    o_bytes_checked++;
                    if (want.err)
                        o_rejects++;
                    if (i_table_byte !== want.value) begin
                        $error("table_byte mismatch: expected %0d, got %0d",
                               want.value, i_table_byte);
                        o_fail_count++;
                    end
                    if (i_last !== want.last) begin
                        $error("last mismatch: expected %0b, got %0b", want.last, i_last);
                        o_fail_count++;
                    end
                    if (i_error !== want.err) begin
                        $error("error mismatch: expected %0b, got %0b", want.err, i_error);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = expected_bytes.size();
    end

endmodule

### dv/testbench.sv
// Top of the pc/line delta table encoder testbench: clock, reset, stimulus and
// output stall pattern. Depends on pcldt_pkg, pc_line_delta_table_encoder_core
// and pcldt_table_checker.
module testbench import pcldt_pkg::*;;

    localparam int                   RANDOM_ITEMS  = 400;
    localparam int                   LONG_HOLD     = 400;
    localparam int                   SETTLE_CYCLES = 16;
    localparam logic [LINE_BITS-1:0] LINE_MAX      = '1;

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} t_stall_mode;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    logic                 i_req_type;
    logic [31:0]          i_pc;
    logic [LINE_BITS-1:0] i_line;
    logic                 i_skip;
    logic                 o_valid;
    logic                 i_stall;
    logic [BYTE_BITS-1:0] o_table_byte;
    logic                 o_last;
    logic                 o_error;

    int fail_count;
    int n_pending;
    int n_bytes;
    int n_rejects;

    logic [31:0]          cur_pc;
    logic [LINE_BITS-1:0] cur_line;
    int                   burst_left;
    int                   n_records;
    int                   n_ends;
    int                   n_skips;
    logic                 hold_req;
    logic                 hold_served;
    logic                 hold_active;

    pc_line_delta_table_encoder_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_req_type   (i_req_type),
        .i_pc         (i_pc),
        .i_line       (i_line),
        .i_skip       (i_skip),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_table_byte (o_table_byte),
        .o_last       (o_last),
        .o_error      (o_error)
    );

    pcldt_table_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_valid),
        .i_in_stall      (o_stall),
        .i_req_type      (i_req_type),
        .i_pc            (i_pc),
        .i_line          (i_line),
        .i_skip          (i_skip),
        .i_out_valid     (o_valid),
        .i_out_stall     (i_stall),
        .i_table_byte    (o_table_byte),
        .i_last          (o_last),
        .i_error         (o_error),
        .o_fail_count    (fail_count),
        .o_pending       (n_pending),
        .o_bytes_checked (n_bytes),
        .o_rejects       (n_rejects)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    initial begin
        #8_000_000;
        $display("simulation failed");
        $finish;
    end

    // output side: random stall modes, plus one long hold-off on request
    initial begin : receiver
        t_stall_mode mode;
        int          left;
        int          hold_left;
        int          phase;
        i_stall = 1'b0;
        hold_served = 1'b0;
        hold_active = 1'b0;
        mode = STALL_NONE;
        left = 0;
        hold_left = 0;
        phase = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_served) begin
                hold_left = LONG_HOLD;
                hold_served = 1'b1;
            end
            if (left == 0) begin
                mode = t_stall_mode'($urandom_range(0, 3));
                left = $urandom_range(16, 96);
            end
            left--;
            phase++;
            hold_active = (hold_left > 0);
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                case (mode)
                    STALL_NONE:  i_stall <= 1'b0;
                    STALL_LIGHT: i_stall <= ($urandom_range(0, 3) == 0);
                    STALL_HEAVY: i_stall <= ($urandom_range(0, 3) != 0);
                    default:     i_stall <= ((phase % 7) < 3);
                endcase
            end
        end
    end

    task automatic send_item(input logic req, input logic [31:0] pc,
                             input logic [LINE_BITS-1:0] line, input logic skip);
        i_valid <= 1'b1;
        i_req_type <= req;
        i_pc <= pc;
        i_line <= line;
        i_skip <= skip;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        @(negedge i_clk);
        if (req == REQ_END)
            n_ends++;
        else if (skip)
            n_skips++;
        else
            n_records++;
        if (burst_left > 0) begin
            burst_left--;
        end else if (!(hold_req && (!hold_served || hold_active))) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(0, 10);
        end
    endtask

    // well-formed record: advances the stream cursor
    task automatic send_good(input int unsigned gap, input logic [LINE_BITS-1:0] line);
        logic [31:0] pc;
        pc = cur_pc + gap;
        send_item(REQ_RECORD, pc, line, 1'b0);
        cur_pc = pc + 32'd2;
        cur_line = line;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (n_pending != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 88)
            return $urandom_range(0, 40);
        if (r < 97)
            return $urandom_range(41, 2000);
        return $urandom_range(2 * ADV_LIMIT - 3, 2 * ADV_LIMIT + 1);
    endfunction

    function automatic logic [LINE_BITS-1:0] pick_line(input logic [LINE_BITS-1:0] from);
        int unsigned          r;
        longint               d;
        longint               t;
        logic [LINE_BITS-1:0] v;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            d = $urandom_range(1, 64);
        end else if (r < 65) begin
            d = $urandom_range(64, 65);
        end else if (r < 85) begin
            d = $urandom_range(66, 100000);
        end else begin
            v = LINE_BITS'($urandom);
            return (v == from) ? ~from : v;
        end
        if ($urandom_range(0, 1))
            d = -d;
        t = longint'(from) + d;
        if (t < 0 || t > longint'(LINE_MAX))
            t = longint'(from) - d;
        return t[LINE_BITS-1:0];
    endfunction

    initial begin : stimulus
        int          k;
        int unsigned pick;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_req_type = REQ_RECORD;
        i_pc = '0;
        i_line = '0;
        i_skip = 1'b0;
        hold_req = 1'b0;
        cur_pc = '0;
        cur_line = '0;
        burst_left = 0;
        n_records = 0;
        n_ends = 0;
        n_skips = 0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: boundaries of the byte codes, errors and padding
        send_item(REQ_END, '1, LINE_MAX, 1'b1);
        send_item(REQ_RECORD, '0, '0, 1'b0);
        send_good(0, 1);
        send_item(REQ_END, '0, '0, 1'b0);
        send_item(REQ_RECORD, 32'd100, 50, 1'b1);
        send_good(2 * ADV_STEP_MAX, 65);
        send_good(3, 1);
        send_good(0, 66);
        send_good(0, 1);
        send_good(0, 2);
        send_item(REQ_RECORD, 32'd100, 5, 1'b0);
        send_good(2 * ADV_LIMIT, LINE_MAX);
        send_item(REQ_RECORD, cur_pc + 2 * (ADV_LIMIT + 1), 3, 1'b0);
        send_good(2 * ADV_LIMIT + 1, 0);
        send_item(REQ_RECORD, 32'h8000_0000, 7, 1'b0);
        send_item(REQ_RECORD, cur_pc, '0, 1'b0);
        send_item(REQ_RECORD, '1, 9, 1'b0);
        send_item(REQ_END, '0, '0, 1'b0);
        send_item(REQ_END, '0, '0, 1'b0);
        drain();

        for (k = 0; k < RANDOM_ITEMS; k++) begin
            if (k == RANDOM_ITEMS * 3 / 8)
                hold_req = 1'b1;
            if (k == RANDOM_ITEMS * 3 / 4)
                drain();
            pick = $urandom_range(0, 99);
            if (pick < 60)
                send_good(pick_gap(), pick_line(cur_line));
            else if (pick < 68)
                send_item(REQ_RECORD, $urandom, LINE_BITS'($urandom), 1'b1);
            else if (pick < 78)
                send_item(REQ_END, $urandom, LINE_BITS'($urandom), 1'($urandom_range(0, 1)));
            else if (pick < 84)
                send_item(REQ_RECORD, cur_pc + $urandom_range(0, 40), cur_line, 1'b0);
            else if (pick < 92)
                send_item(REQ_RECORD, cur_pc - $urandom_range(1, 64), pick_line(cur_line),
                          1'b0);
            else if (pick < 96)
                send_item(REQ_RECORD, cur_pc + 2 * (ADV_LIMIT + 1) + $urandom_range(0, 10000),
                          pick_line(cur_line), 1'b0);
            else
                send_item(REQ_RECORD, $urandom, LINE_BITS'($urandom),
                          1'($urandom_range(0, 1)));
        end
        drain();

        $display("sent %0d transactions: %0d records, %0d end markers, %0d skipped",
                 n_records + n_ends + n_skips, n_records, n_ends, n_skips);
        $display("checked %0d table bytes, %0d of them rejections", n_bytes, n_rejects);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

### filelist.f
rtl/core/pcldt_pkg.sv
rtl/core/pcldt_ctrl.sv
rtl/core/pcldt_dp.sv
rtl/core/pc_line_delta_table_encoder_core.sv
dv/pcldt_table_checker.sv
dv/testbench.sv
